@@ sv/utf8sd_pkg.sv @@
`default_nettype none
package utf8sd_pkg;

	localparam int unsigned CpW = 21;
	localparam int unsigned CntW = 3;

	localparam logic [7:0] MaskTop1 = 8'h80;
	localparam logic [7:0] MaskTop2 = 8'hC0;
	localparam logic [7:0] MaskTop3 = 8'hE0;
	localparam logic [7:0] MaskTop4 = 8'hF0;
	localparam logic [7:0] MaskTop5 = 8'hF8;
	localparam logic [7:0] PatCont = 8'h80;
	localparam logic [7:0] PatLead2 = 8'hC0;
	localparam logic [7:0] PatLead3 = 8'hE0;
	localparam logic [7:0] PatLead4 = 8'hF0;
	localparam logic [7:0] PayLead2 = 8'h1F;
	localparam logic [7:0] PayLead3 = 8'h0F;
	localparam logic [7:0] PayLead4 = 8'h07;
	localparam logic [7:0] PayCont = 8'h3F;

	typedef struct packed {
		logic [CpW-1:0]  code_point;
		logic [CntW-1:0] byte_count;
		logic            truncated;
		logic            bad_lead;
		logic            last;
	} res_t;

endpackage
`default_nettype wire

@@ sv/utf8_stream_decoder.sv @@
// a byte is held in the input stage until the result queue has room for its results
// throughput: one byte per cycle; a byte that closes a cut-short sequence and emits
// itself gives two results, and the single master port then drains one per cycle
// the two-entry result queue lets a byte be taken while earlier results wait
// reset (arst_n low, asynchronous): no sequence open, queue empty, input stage empty
`default_nettype none
module utf8_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // byte_in[7:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // code_point[20:0], byte_count[23:21]
	output logic [1:0]       m_axis_tuser,   // truncated[0], bad_lead[1]
	output logic             m_axis_tlast
);

	localparam int unsigned CpW = utf8sd_pkg::CpW;
	localparam int unsigned CntW = utf8sd_pkg::CntW;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state
	logic [CpW-1:0]  pv_q;
	logic [1:0]      need_q;
	logic [CntW-1:0] taken_q;

	// result queue, slot 0 is the head
	utf8sd_pkg::res_t slot0_q, slot1_q;
	logic [1:0]       cnt_q;

	// decode
	logic             is_cont, open, lead_emit;
	logic [1:0]       n_res;
	utf8sd_pkg::res_t r0, r1, lead_res;
	logic [CpW-1:0]   pv_d, pv_shift;
	logic [1:0]       need_d;
	logic [CntW-1:0]  taken_d, taken_inc;
	logic             process;

	// queue control
	logic             pop;
	logic [1:0]       cnt_pop, cnt_d;
	utf8sd_pkg::res_t e0, e1;

	always_comb begin
		is_cont   = (byte_s1 & utf8sd_pkg::MaskTop2) == utf8sd_pkg::PatCont;
		open      = need_q != 2'd0;
		pv_shift  = {pv_q[CpW-7:0], byte_s1[5:0]};
		taken_inc = taken_q + CntW'(1);

		lead_res.code_point = CpW'(byte_s1);
		lead_res.byte_count = CntW'(1);
		lead_res.truncated  = 1'b0;
		lead_res.bad_lead   = 1'b0;
		lead_res.last       = 1'b1;

		r0 = lead_res;
		r1 = lead_res;
		n_res = 2'd0;
		lead_emit = 1'b0;
		pv_d = pv_q;
		need_d = need_q;
		taken_d = taken_q;

		if (open && is_cont) begin
			pv_d    = pv_shift;
			taken_d = taken_inc;
			need_d  = need_q - 2'd1;
			if (need_q == 2'd1) begin
				r0.code_point = pv_shift;
				r0.byte_count = taken_inc;
				n_res   = 2'd1;
				pv_d    = '0;
				taken_d = '0;
			end
		end else begin
			pv_d    = '0;
			need_d  = 2'd0;
			taken_d = '0;
			if (!byte_s1[7]) begin
				lead_emit = 1'b1;
			end else if ((byte_s1 & utf8sd_pkg::MaskTop3) == utf8sd_pkg::PatLead2) begin
				pv_d    = CpW'(byte_s1 & utf8sd_pkg::PayLead2);
				need_d  = 2'd1;
				taken_d = CntW'(1);
			end else if ((byte_s1 & utf8sd_pkg::MaskTop4) == utf8sd_pkg::PatLead3) begin
				pv_d    = CpW'(byte_s1 & utf8sd_pkg::PayLead3);
				need_d  = 2'd2;
				taken_d = CntW'(1);
			end else if ((byte_s1 & utf8sd_pkg::MaskTop5) == utf8sd_pkg::PatLead4) begin
				pv_d    = CpW'(byte_s1 & utf8sd_pkg::PayLead4);
				need_d  = 2'd3;
				taken_d = CntW'(1);
			end else begin
				lead_emit = 1'b1;
				lead_res.bad_lead = 1'b1;
			end
			r1 = lead_res;
			if (open) begin
				r0.code_point = pv_q;
				r0.byte_count = taken_q;
				r0.truncated  = 1'b1;
				r0.bad_lead   = 1'b0;
				r0.last       = !lead_emit;
				n_res = lead_emit ? 2'd2 : 2'd1;
			end else begin
				r0 = lead_res;
				n_res = lead_emit ? 2'd1 : 2'd0;
			end
		end
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign cnt_pop       = cnt_q - {1'b0, pop};
	assign process       = valid_s1 && ({1'b0, n_res} <= (3'd2 - {1'b0, cnt_pop}));
	assign s_axis_tready = !valid_s1 || process;

	always_comb begin
		e0 = pop ? slot1_q : slot0_q;
		e1 = slot1_q;
		cnt_d = cnt_pop;
		if (process && n_res != 2'd0) begin
			if (cnt_pop == 2'd0) begin
				e0 = r0;
				e1 = r1;
			end else begin
				e1 = r0;
			end
			cnt_d = cnt_pop + n_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pv_q     <= '0;
			need_q   <= 2'd0;
			taken_q  <= '0;
			cnt_q    <= 2'd0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (process) begin
				pv_q    <= pv_d;
				need_q  <= need_d;
				taken_q <= taken_d;
			end
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		slot0_q <= e0;
		slot1_q <= e1;
	end

	assign m_axis_tdata = {slot0_q.byte_count, slot0_q.code_point};
	assign m_axis_tuser = {slot0_q.bad_lead, slot0_q.truncated};
	assign m_axis_tlast = slot0_q.last;

endmodule
`default_nettype wire

@@ dv/tb_utf8_stream_decoder.sv @@
`timescale 1ns / 1ps

class utf8_scoreboard;
	utf8sd_pkg::res_t            due_cps[$];
	logic [utf8sd_pkg::CpW-1:0]  partial_cp;
	logic [1:0]                  conts_left;
	logic [utf8sd_pkg::CntW-1:0] bytes_seen;
	int                          errors;

	function new();
		partial_cp = '0;
		conts_left = '0;
		bytes_seen = '0;
		errors = 0;
	endfunction

	function automatic bit take_lead(input logic [7:0] b, output utf8sd_pkg::res_t r);
		r = '0;
		if ((b & utf8sd_pkg::MaskTop1) == 8'h00) begin
			r.code_point = utf8sd_pkg::CpW'(b);
			r.byte_count = utf8sd_pkg::CntW'(1);
			r.last = 1'b1;
			return 1'b1;
		end
		if ((b & utf8sd_pkg::MaskTop3) == utf8sd_pkg::PatLead2) begin
			partial_cp = utf8sd_pkg::CpW'(b & utf8sd_pkg::PayLead2);
			conts_left = 2'd1;
		end else if ((b & utf8sd_pkg::MaskTop4) == utf8sd_pkg::PatLead3) begin
			partial_cp = utf8sd_pkg::CpW'(b & utf8sd_pkg::PayLead3);
			conts_left = 2'd2;
		end else if ((b & utf8sd_pkg::MaskTop5) == utf8sd_pkg::PatLead4) begin
			partial_cp = utf8sd_pkg::CpW'(b & utf8sd_pkg::PayLead4);
			conts_left = 2'd3;
		end else begin
			r.code_point = utf8sd_pkg::CpW'(b);
			r.byte_count = utf8sd_pkg::CntW'(1);
			r.bad_lead = 1'b1;
			r.last = 1'b1;
			return 1'b1;
		end
		bytes_seen = utf8sd_pkg::CntW'(1);
		return 1'b0;
	endfunction

	// decode one accepted byte and queue the code points it gives
	function void decode_byte(input logic [7:0] b);
		utf8sd_pkg::res_t cut;
		utf8sd_pkg::res_t r;
		bit               cut_open;
		cut = '0;
		cut_open = 1'b0;
		if (conts_left != 2'd0 && (b & utf8sd_pkg::MaskTop2) == utf8sd_pkg::PatCont) begin
			partial_cp = {partial_cp[utf8sd_pkg::CpW-7:0], b[5:0]};
			bytes_seen = bytes_seen + utf8sd_pkg::CntW'(1);
			conts_left = conts_left - 2'd1;
			if (conts_left == 2'd0) begin
				r = '0;
				r.code_point = partial_cp;
				r.byte_count = bytes_seen;
				r.last = 1'b1;
				due_cps.push_back(r);
				partial_cp = '0;
				bytes_seen = '0;
			end
			return;
		end
		if (conts_left != 2'd0) begin
			cut.code_point = partial_cp;
			cut.byte_count = bytes_seen;
			cut.truncated = 1'b1;
			cut.last = 1'b1;
			cut_open = 1'b1;
			partial_cp = '0;
			conts_left = '0;
			bytes_seen = '0;
		end
		if (take_lead(b, r)) begin
			if (cut_open) begin
				cut.last = 1'b0;
				due_cps.push_back(cut);
			end
			due_cps.push_back(r);
		end else if (cut_open) begin
			due_cps.push_back(cut);
		end
	endfunction

	function void check_cp(input utf8sd_pkg::res_t got);
		utf8sd_pkg::res_t want;
		if (due_cps.size() == 0) begin
			$display("%0t: unexpected result cp=%h cnt=%0d trunc=%b bad=%b last=%b", $time,
				got.code_point, got.byte_count, got.truncated, got.bad_lead, got.last);
			errors++;
			return;
		end
		want = due_cps.pop_front();
		if (got !== want) begin
			$display("%0t: expected cp=%h cnt=%0d trunc=%b bad=%b last=%b", $time,
				want.code_point, want.byte_count, want.truncated, want.bad_lead,
				want.last);
			$display("%0t: actual   cp=%h cnt=%0d trunc=%b bad=%b last=%b", $time,
				got.code_point, got.byte_count, got.truncated, got.bad_lead, got.last);
			errors++;
		end
	endfunction
endclass

module tb_utf8_stream_decoder;

	localparam int CycleLimit = 200000;
	localparam int ItemsPerPhase = 134;
	localparam logic [7:0] DirBytes [26] = '{
		8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
		8'hC2, 8'hA9,
		8'hE2, 8'h82, 8'hAC,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hC3, 8'h41,
		8'hE2, 8'h82, 8'h00,
		8'hE2, 8'hC3, 8'hA9,
		8'hF0, 8'h90, 8'hFF
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int unsigned    send_idle_pct = 0;
	int unsigned    recv_stall_pct = 0;
	int             cycles = 0;
	utf8_scoreboard sb = new();

	utf8_stream_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		utf8sd_pkg::res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.code_point = m_tdata[20:0];
			got.byte_count = m_tdata[23:21];
			got.truncated = m_tuser[0];
			got.bad_lead = m_tuser[1];
			got.last = m_tlast;
			sb.check_cp(got);
		end
	end

	initial begin
		wait (cycles >= CycleLimit);
		$display("Some tests failed");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the byte is accepted
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.decode_byte(b);
		@(negedge clk);
	endtask

	// mostly well-formed sequences, some cut short, some noise
	task automatic send_seq(inout int sent);
		int unsigned pick;
		int unsigned len;
		int unsigned conts;
		logic [31:0] bits;
		logic [7:0]  lead;
		pick = $urandom_range(99);
		bits = $urandom;
		if (pick < 20) begin
			send_byte(bits[7:0]);
			sent++;
			return;
		end
		len = $urandom_range(4, 1);
		case (len)
			1: begin
				lead = bits[7:0] & ~utf8sd_pkg::MaskTop1;
			end
			2: begin
				lead = utf8sd_pkg::PatLead2 | (bits[7:0] & utf8sd_pkg::PayLead2);
			end
			3: begin
				lead = utf8sd_pkg::PatLead3 | (bits[7:0] & utf8sd_pkg::PayLead3);
			end
			default: begin
				lead = utf8sd_pkg::PatLead4 | (bits[7:0] & utf8sd_pkg::PayLead4);
			end
		endcase
		conts = len - 1;
		if (pick < 35 && len > 1)
			conts = $urandom_range(len - 2);
		send_byte(lead);
		sent++;
		repeat (conts) begin
			bits = $urandom;
			send_byte(utf8sd_pkg::PatCont | (bits[7:0] & utf8sd_pkg::PayCont));
			sent++;
		end
	endtask

	initial begin
		int sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 15;
		recv_stall_pct = 60;
		foreach (DirBytes[i])
			send_byte(DirBytes[i]);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				// hold off until the decoder has drained
				s_tvalid <= 1'b0;
				while (sb.due_cps.size() != 0)
					@(posedge clk);
				@(negedge clk);
				send_idle_pct = 60;
				recv_stall_pct = 15;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			sent = 0;
			while (sent < ItemsPerPhase)
				send_seq(sent);
		end
		s_tvalid <= 1'b0;

		while (sb.due_cps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.due_cps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
